// ===== rtl/core/dcg_pkg.sv =====
// Package for the drive command gate: word types, config bundle, codes.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dcg_pkg;

    // Input word: decoded frame or millisecond tick
    typedef struct packed {
        logic        kind;
        logic [7:0]  msg_type;
        logic [7:0]  body_len;
        logic [15:0] first_word;
        logic [15:0] second_word;
        logic [7:0]  brake_byte;
        logic [31:0] sequence_req;
    } t_in_word;

    // Result word: acknowledgement plus latched command status
    typedef struct packed {
        logic               ack_sent;
        logic [7:0]         ack_type;
        logic [1:0]         ack_status;
        logic [31:0]        ack_sequence;
        logic signed [15:0] left_drive;
        logic signed [15:0] right_drive;
        logic               brake;
        logic [31:0]        command_sequence;
        logic               command_valid;
        logic               connected;
        logic [31:0]        age_ms;
    } t_out_word;

    // Configuration bundle handed from the register file to the checker
    typedef struct packed {
        logic [7:0]  probe_type_code;
        logic [7:0]  control_type_code;
        logic [7:0]  control_length;
        logic [14:0] drive_limit;
        logic [15:0] timeout_ms;
        logic        require_probe;
    } t_cfg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_TYPE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_TYPE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_PROBE    = 3'd5;

    // Register reset values
    localparam logic [7:0]  RST_PROBE_TYPE   = 8'd1;
    localparam logic [7:0]  RST_CONTROL_TYPE = 8'd2;
    localparam logic [7:0]  RST_CONTROL_LEN  = 8'd5;
    localparam logic [14:0] RST_DRIVE_LIMIT  = 15'd1000;
    localparam logic [15:0] RST_TIMEOUT      = 16'd500;

    // Item kinds
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // Sender roles
    localparam logic [1:0] ROLE_NONE      = 2'd0;
    localparam logic [1:0] ROLE_PRIMARY   = 2'd1;
    localparam logic [1:0] ROLE_SECONDARY = 2'd2;

    // Ack status codes
    localparam logic [1:0] ACK_OK        = 2'd0;
    localparam logic [1:0] ACK_BAD_FRAME = 2'd1;
    localparam logic [1:0] ACK_BAD_DATA  = 2'd2;

    localparam logic [7:0]  PROBE_LEN = 8'd1;
    localparam logic [31:0] AGE_MAX   = 32'hFFFF_FFFF;

endpackage

// ===== rtl/core/dcg_cfg_regs.sv =====
// Configuration register file of the drive command gate.
// Depends on dcg_pkg for the config bundle, register indexes and resets.
`timescale 1ns / 1ps

module dcg_cfg_regs
    import dcg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Write one register per enabled cycle; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.probe_type_code   <= RST_PROBE_TYPE;
            r_cfg.control_type_code <= RST_CONTROL_TYPE;
            r_cfg.control_length    <= RST_CONTROL_LEN;
            r_cfg.drive_limit       <= RST_DRIVE_LIMIT;
            r_cfg.timeout_ms        <= RST_TIMEOUT;
            r_cfg.require_probe     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PROBE_TYPE: begin
                    r_cfg.probe_type_code <= i_cfg_wdata[7:0];
                end
                CFG_CONTROL_TYPE: begin
                    r_cfg.control_type_code <= i_cfg_wdata[7:0];
                end
                CFG_CONTROL_LEN: begin
                    r_cfg.control_length <= i_cfg_wdata[7:0];
                end
                CFG_DRIVE_LIMIT: begin
                    r_cfg.drive_limit <= i_cfg_wdata[14:0];
                end
                CFG_TIMEOUT: begin
                    r_cfg.timeout_ms <= i_cfg_wdata[15:0];
                end
                CFG_REQ_PROBE: begin
                    r_cfg.require_probe <= i_cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/dcg_check.sv =====
// Frame checker and command latch: judges one word, updates the link state
// and forms the result word. Depends on dcg_pkg.
`timescale 1ns / 1ps

module dcg_check
    import dcg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_advance,
    input  t_in_word  i_word,
    output t_out_word o_result
);

    // Link state
    logic [1:0]  r_sender_role, n_sender_role;
    logic [31:0] r_last_seq,    n_last_seq;
    logic        r_seq_seen,    n_seq_seen;
    logic [15:0] r_left,        n_left;
    logic [15:0] r_right,       n_right;
    logic        r_brake,       n_brake;
    logic        r_valid,       n_valid;
    logic [31:0] r_age,         n_age;

    logic [7:0]  role;
    logic        is_probe;
    logic        frame_bad;
    logic        data_bad;
    logic        left_ok;
    logic        right_ok;
    logic        seq_new;
    logic [31:0] seq_diff;
    logic signed [16:0] lim_pos;
    logic signed [16:0] lim_neg;
    logic signed [16:0] left_ext;
    logic signed [16:0] right_ext;
    logic [1:0]  ack_status;

    // Decode the frame tests
    always_comb begin
        role      = i_word.first_word[7:0];
        is_probe  = (i_word.msg_type == i_cfg.probe_type_code) &&
                    (i_word.body_len == PROBE_LEN) &&
                    ((role == {6'd0, ROLE_PRIMARY}) || (role == {6'd0, ROLE_SECONDARY}));
        frame_bad = (i_word.msg_type != i_cfg.control_type_code) ||
                    (i_word.body_len != i_cfg.control_length) ||
                    (i_cfg.require_probe && (r_sender_role != ROLE_PRIMARY));
        lim_pos   = $signed({2'b00, i_cfg.drive_limit});
        lim_neg   = -lim_pos;
        left_ext  = $signed({i_word.first_word[15], i_word.first_word});
        right_ext = $signed({i_word.second_word[15], i_word.second_word});
        left_ok   = (left_ext >= lim_neg) && (left_ext <= lim_pos);
        right_ok  = (right_ext >= lim_neg) && (right_ext <= lim_pos);
        seq_diff  = i_word.sequence_req - r_last_seq;
        seq_new   = !r_seq_seen || ((seq_diff != 32'd0) && !seq_diff[31]);
        data_bad  = !left_ok || !right_ok || (i_word.brake_byte > 8'd1) || !seq_new;
    end

    // Next state and ack status
    always_comb begin
        n_sender_role = r_sender_role;
        n_last_seq    = r_last_seq;
        n_seq_seen    = r_seq_seen;
        n_left        = r_left;
        n_right       = r_right;
        n_brake       = r_brake;
        n_valid       = r_valid;
        n_age         = r_age;
        ack_status    = ACK_OK;
        if (i_word.kind == KIND_TICK) begin
            if (r_valid && (r_age != AGE_MAX)) begin
                n_age = r_age + 32'd1;
            end
        end else if (is_probe) begin
            n_sender_role = role[1:0];
        end else if (frame_bad) begin
            ack_status = ACK_BAD_FRAME;
        end else if (data_bad) begin
            ack_status = ACK_BAD_DATA;
        end else begin
            n_left     = i_word.first_word;
            n_right    = i_word.second_word;
            n_brake    = i_word.brake_byte[0];
            n_last_seq = i_word.sequence_req;
            n_seq_seen = 1'b1;
            n_valid    = 1'b1;
            n_age      = 32'd0;
        end
    end

    // Form the result from the state after this word
    always_comb begin
        o_result.ack_sent         = (i_word.kind == KIND_FRAME);
        o_result.ack_type         = (i_word.kind == KIND_FRAME) ? i_word.msg_type : 8'd0;
        o_result.ack_status       = (i_word.kind == KIND_FRAME) ? ack_status : ACK_OK;
        o_result.ack_sequence     = (i_word.kind == KIND_FRAME) ? i_word.sequence_req : 32'd0;
        o_result.left_drive       = $signed(n_left);
        o_result.right_drive      = $signed(n_right);
        o_result.brake            = n_brake;
        o_result.command_sequence = n_seq_seen ? n_last_seq : 32'd0;
        o_result.command_valid    = n_valid;
        o_result.connected        = n_valid && (n_age <= {16'd0, i_cfg.timeout_ms});
        o_result.age_ms           = n_valid ? n_age : 32'd0;
    end

    // Commit the state when the word moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sender_role <= ROLE_NONE;
            r_last_seq    <= 32'd0;
            r_seq_seen    <= 1'b0;
            r_left        <= 16'd0;
            r_right       <= 16'd0;
            r_brake       <= 1'b0;
            r_valid       <= 1'b0;
            r_age         <= 32'd0;
        end else if (i_advance) begin
            r_sender_role <= n_sender_role;
            r_last_seq    <= n_last_seq;
            r_seq_seen    <= n_seq_seen;
            r_left        <= n_left;
            r_right       <= n_right;
            r_brake       <= n_brake;
            r_valid       <= n_valid;
            r_age         <= n_age;
        end
    end

endmodule

// ===== rtl/core/drive_command_gate_unit.sv =====
// Drive command gate: an accepted word sits in the input register, then
// moves to the result register, where it shows as a valid result; a stall on
// the output holds it in place. Throughput one word per cycle while the output
// is not stalled, set by the combinational check between the two registers.
// Synchronous active-low reset clears both valid flags, the link state
// (no role, no command, age 0) and loads the register defaults.
`timescale 1ns / 1ps

module drive_command_gate_unit
    import dcg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in_word              i_in,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_out_word             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg      cfg;
    t_out_word result;
    t_in_word  r_in_word;
    logic      r_in_valid;
    t_out_word r_out_word;
    logic      r_out_valid;
    logic      advance;
    logic      out_free;

    dcg_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    dcg_check u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_advance (advance),
        .i_word    (r_in_word),
        .o_result  (result)
    );

    // Handshake: advance when the result register is free or being drained
    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_word <= i_in;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_word <= result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out_word;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for drive_command_gate_unit: directed and random frames and ticks,
// with every result word compared against a gate predictor kept in this file.
// Depends on dcg_pkg and the gate RTL only.

module tb_top;
    import dcg_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 60;
    localparam int PHASE_ITEMS    = 305;
    localparam int PRINT_CAP      = 40;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  o_ready;
    t_in_word              in_word   = '0;
    logic                  o_valid;
    logic                  out_ready = 1'b0;
    t_out_word             o_out;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_PROBE_TYPE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Words waiting to be offered, and result words predicted but not yet seen
    t_in_word  in_backlog[$];
    t_out_word status_due[$];

    // Predictor copy of the register file and the link state
    t_cfg        m_cfg;
    logic [1:0]  m_role;
    logic [31:0] m_last_seq;
    logic        m_seq_seen;
    logic [15:0] m_left;
    logic [15:0] m_right;
    logic        m_brake;
    logic        m_cmd_valid;
    logic [31:0] m_age;

    // Running sequence used to build frames that count as newer
    logic [31:0] gen_seq;

    bit          calm        = 1'b0;
    bit          in_hs       = 1'b0;
    int unsigned tx_gap      = 0;
    int unsigned rx_stall    = 0;
    int unsigned hold_left   = 0;
    int unsigned holds_done  = 0;
    int unsigned hold_mark   = 150;
    int unsigned idle_cycles = 0;
    int unsigned n_errors    = 0;
    int unsigned n_in        = 0;
    int unsigned n_out       = 0;
    int unsigned n_ticks     = 0;
    int unsigned n_ok        = 0;
    int unsigned n_bad_frame = 0;
    int unsigned n_bad_data  = 0;
    int unsigned n_conn      = 0;
    int unsigned n_settings  = 1;

    drive_command_gate_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .o_ready     (o_ready),
        .i_in        (in_word),
        .o_valid     (o_valid),
        .i_ready     (out_ready),
        .o_out       (o_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Check one signed permille drive against the current limit
    function automatic logic drive_in_limit(logic [15:0] raw);
        int v;
        int lim;
        v   = int'($signed(raw));
        lim = int'(m_cfg.drive_limit);
        return (v >= -lim) && (v <= lim);
    endfunction

    // Apply one word to the predicted link state and build its result word
    function automatic t_out_word gate_result(t_in_word w);
        t_out_word   r;
        logic [31:0] seq_gap;
        logic        fresh;
        r = '0;
        if (w.kind == KIND_TICK) begin
            if (m_cmd_valid && m_age != AGE_MAX) m_age = m_age + 32'd1;
        end else begin
            r.ack_sent     = 1'b1;
            r.ack_type     = w.msg_type;
            r.ack_sequence = w.sequence_req;
            seq_gap = w.sequence_req - m_last_seq;
            fresh   = !m_seq_seen || (seq_gap != 32'd0 && !seq_gap[31]);
            if (w.msg_type == m_cfg.probe_type_code && w.body_len == PROBE_LEN &&
                (w.first_word[7:0] == ROLE_PRIMARY || w.first_word[7:0] == ROLE_SECONDARY)) begin
                m_role       = w.first_word[1:0];
                r.ack_status = ACK_OK;
            end else if (w.msg_type != m_cfg.control_type_code ||
                         w.body_len != m_cfg.control_length ||
                         (m_cfg.require_probe && m_role != ROLE_PRIMARY)) begin
                r.ack_status = ACK_BAD_FRAME;
            end else if (!drive_in_limit(w.first_word) || !drive_in_limit(w.second_word) ||
                         w.brake_byte > 8'd1 || !fresh) begin
                r.ack_status = ACK_BAD_DATA;
            end else begin
                m_left       = w.first_word;
                m_right      = w.second_word;
                m_brake      = w.brake_byte[0];
                m_last_seq   = w.sequence_req;
                m_seq_seen   = 1'b1;
                m_cmd_valid  = 1'b1;
                m_age        = '0;
                r.ack_status = ACK_OK;
            end
        end
        r.left_drive       = m_left;
        r.right_drive      = m_right;
        r.brake            = m_brake;
        r.command_sequence = m_seq_seen ? m_last_seq : '0;
        r.command_valid    = m_cmd_valid;
        r.connected        = m_cmd_valid && (m_age <= {16'd0, m_cfg.timeout_ms});
        r.age_ms           = m_cmd_valid ? m_age : '0;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        n_errors++;
        if (n_errors <= PRINT_CAP) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d field %s: got %0h, want %0h",
                                      n_out, name, got, want));
        end
    endtask

    task automatic check_result(t_out_word got, t_out_word want);
        compare_field("ack_sent", got.ack_sent, want.ack_sent);
        compare_field("ack_type", got.ack_type, want.ack_type);
        compare_field("ack_status", got.ack_status, want.ack_status);
        compare_field("ack_sequence", got.ack_sequence, want.ack_sequence);
        compare_field("left_drive", got.left_drive, want.left_drive);
        compare_field("right_drive", got.right_drive, want.right_drive);
        compare_field("brake", got.brake, want.brake);
        compare_field("command_sequence", got.command_sequence, want.command_sequence);
        compare_field("command_valid", got.command_valid, want.command_valid);
        compare_field("connected", got.connected, want.connected);
        compare_field("age_ms", got.age_ms, want.age_ms);
    endtask

    // Tick with random, ignored payload bits
    function automatic t_in_word tick_item();
        t_in_word    w;
        logic [95:0] noise;
        noise  = {$urandom, $urandom, $urandom};
        w      = noise[$bits(t_in_word)-1:0];
        w.kind = KIND_TICK;
        return w;
    endfunction

    function automatic t_in_word frame_item(logic [7:0] ftype, logic [7:0] len,
                                            logic [15:0] w0, logic [15:0] w1,
                                            logic [7:0] brk, logic [31:0] seq);
        t_in_word w;
        w.kind         = KIND_FRAME;
        w.msg_type     = ftype;
        w.body_len     = len;
        w.first_word   = w0;
        w.second_word  = w1;
        w.brake_byte   = brk;
        w.sequence_req = seq;
        return w;
    endfunction

    // Control frame under the reset register values
    function automatic t_in_word control_item(logic [15:0] w0, logic [15:0] w1,
                                              logic [7:0] brk, logic [31:0] seq);
        return frame_item(RST_CONTROL_TYPE, RST_CONTROL_LEN, w0, w1, brk, seq);
    endfunction

    // Drive value inside [-lim, lim], extremes weighted up
    function automatic logic [15:0] drive_within(int unsigned lim);
        int v;
        case ($urandom_range(0, 7))
            0:       v = int'(lim);
            1:       v = -int'(lim);
            default: v = int'($urandom_range(0, 2 * lim)) - int'(lim);
        endcase
        return 16'(v);
    endfunction

    // Drive value just or far outside the limit; -32768 is always outside
    function automatic logic [15:0] drive_beyond(int unsigned lim);
        int unsigned mag;
        mag = $urandom_range(lim + 1, 32768);
        if (mag == 32768 || $urandom_range(0, 1) == 1) return 16'(-int'(mag));
        return 16'(mag);
    endfunction

    // Mostly well-formed control and probe frames, some with one defect, plus noise
    function automatic t_in_word random_item();
        t_in_word    w;
        int unsigned pick;
        int unsigned lim;
        logic [31:0] prior;
        w      = tick_item();
        w.kind = KIND_FRAME;
        pick   = $urandom_range(0, 99);
        lim    = {17'd0, m_cfg.drive_limit};
        prior  = gen_seq;
        if (pick < 25) begin
            w.kind = KIND_TICK;
        end else if (pick < 82) begin
            w.msg_type    = m_cfg.control_type_code;
            w.body_len    = m_cfg.control_length;
            w.first_word  = drive_within(lim);
            w.second_word = drive_within(lim);
            w.brake_byte  = 8'($urandom_range(0, 1));
            if ($urandom_range(0, 15) == 0) begin
                gen_seq = gen_seq + $urandom_range(1, 32'h7FFF_FFFF);
            end else begin
                gen_seq = gen_seq + $urandom_range(1, 16);
            end
            w.sequence_req = gen_seq;
            // break exactly one rule
            if (pick >= 68) begin
                case ($urandom_range(0, 6))
                    0: w.first_word = drive_beyond(lim);
                    1: w.second_word = drive_beyond(lim);
                    2: w.brake_byte = 8'($urandom_range(2, 255));
                    3: w.sequence_req = prior - $urandom_range(0, 64);
                    4: w.sequence_req = prior + 32'h8000_0000 + $urandom_range(0, 64);
                    5: w.body_len = w.body_len ^ 8'(1 << $urandom_range(0, 7));
                    default: w.msg_type = w.msg_type ^ 8'($urandom_range(1, 255));
                endcase
            end
        end else if (pick < 95) begin
            w.msg_type = m_cfg.probe_type_code;
            w.body_len = PROBE_LEN;
            w.first_word[7:0] = ($urandom_range(0, 3) != 0) ? 8'(ROLE_PRIMARY)
                                                             : 8'(ROLE_SECONDARY);
            if (pick >= 92) begin
                if ($urandom_range(0, 1) == 1) begin
                    w.body_len = ($urandom_range(0, 3) == 0) ? 8'd0
                                                              : 8'($urandom_range(2, 255));
                end else begin
                    w.first_word[7:0] = ($urandom_range(0, 3) == 0) ? 8'(ROLE_NONE)
                                                                     : 8'($urandom_range(3, 255));
                end
            end
        end
        return w;
    endfunction

    // Queue random words, with occasional long runs of ticks to age the command
    task automatic fill_random(int unsigned count);
        int unsigned k;
        int unsigned burst;
        k = 0;
        while (k < count) begin
            if ($urandom_range(0, 39) == 0) begin
                burst = $urandom_range(5, 40);
                repeat (burst) in_backlog.push_back(tick_item());
                k += burst;
            end else begin
                in_backlog.push_back(random_item());
                k++;
            end
        end
    endtask

    // Hold until every word is offered, taken and answered, then let the pipe settle
    task automatic await_drain();
        @(posedge i_clk);
        #1;
        while (in_backlog.size() != 0 || in_valid || status_due.size() != 0) begin
            @(posedge i_clk);
            #1;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
    endtask

    // Write all six registers back to back, then mirror them in the predictor
    task automatic load_config(t_cfg c);
        write_reg(CFG_PROBE_TYPE, 16'(c.probe_type_code));
        write_reg(CFG_CONTROL_TYPE, 16'(c.control_type_code));
        write_reg(CFG_CONTROL_LEN, 16'(c.control_length));
        write_reg(CFG_DRIVE_LIMIT, 16'(c.drive_limit));
        write_reg(CFG_TIMEOUT, c.timeout_ms);
        write_reg(CFG_REQ_PROBE, 16'(c.require_probe));
        @(negedge i_clk);
        cfg_we <= 1'b0;
        m_cfg = c;
        n_settings++;
    endtask

    // Input driver: hold an offered word until taken, otherwise idle or offer the next
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_hs) begin
            // hold the word and its valid
        end else if (tx_gap != 0) begin
            tx_gap   <= tx_gap - 1;
            in_valid <= 1'b0;
        end else if (in_backlog.size() == 0) begin
            in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            tx_gap   <= $urandom_range(0, 8);
            in_valid <= 1'b0;
        end else begin
            in_word  <= in_backlog.pop_front();
            in_valid <= 1'b1;
        end
    end

    // Result receiver: random stall bursts and two long hold-offs that back up the gate
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (holds_done < 2 && n_out >= hold_mark) begin
            hold_left  <= LONG_HOLD - 1;
            holds_done <= holds_done + 1;
            hold_mark  <= hold_mark + 850;
            out_ready  <= 1'b0;
        end else if (rx_stall != 0) begin
            rx_stall  <= rx_stall - 1;
            out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            rx_stall  <= $urandom_range(0, 8);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Predict on input accept, check on output accept, watch for a stuck link
    always @(posedge i_clk) begin
        t_out_word want;
        in_hs = i_rst_n && in_valid && o_ready;
        if (in_hs) begin
            status_due.push_back(gate_result(in_word));
            n_in++;
        end
        if (i_rst_n && o_valid && out_ready) begin
            n_out++;
            if (status_due.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing predicted", n_out));
            end else begin
                want = status_due.pop_front();
                check_result(o_out, want);
                if (!want.ack_sent) n_ticks++;
                else if (want.ack_status == ACK_OK) n_ok++;
                else if (want.ack_status == ACK_BAD_FRAME) n_bad_frame++;
                else n_bad_data++;
                if (want.connected) n_conn++;
            end
        end
        if (in_hs || (o_valid && out_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles, %0d results outstanding",
                     idle_cycles, status_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stimulus: reset, directed words, then random phases under several register settings
    initial begin
        t_cfg c;
        m_cfg       = '{RST_PROBE_TYPE, RST_CONTROL_TYPE, RST_CONTROL_LEN,
                        RST_DRIVE_LIMIT, RST_TIMEOUT, 1'b0};
        m_role      = ROLE_NONE;
        m_last_seq  = '0;
        m_seq_seen  = 1'b0;
        m_left      = '0;
        m_right     = '0;
        m_brake     = 1'b0;
        m_cmd_valid = 1'b0;
        m_age       = '0;
        gen_seq     = 32'h8000_0000;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // tick with no command; wrong type, wrong length, malformed probes
        in_backlog.push_back(tick_item());
        in_backlog.push_back(frame_item(8'd3, RST_CONTROL_LEN, '0, '0, 8'd0, 32'd10));
        in_backlog.push_back(frame_item(RST_CONTROL_TYPE, 8'd4, '0, '0, 8'd0, 32'd10));
        in_backlog.push_back(frame_item(RST_PROBE_TYPE, PROBE_LEN, 16'h0003, '0, 8'd0, 32'd11));
        in_backlog.push_back(frame_item(RST_PROBE_TYPE, 8'd2, 16'(ROLE_PRIMARY), '0, 8'd0,
                                        32'd12));
        // good probes; the high byte of the role word is ignored
        in_backlog.push_back(frame_item(RST_PROBE_TYPE, PROBE_LEN, {8'hAB, 6'd0, ROLE_SECONDARY},
                                        16'hFFFF, 8'hFF, 32'd13));
        in_backlog.push_back(frame_item(RST_PROBE_TYPE, PROBE_LEN, 16'(ROLE_PRIMARY), '0, 8'd0,
                                        32'd14));
        // first command takes any sequence; equal is refused; wrap to zero is newer
        in_backlog.push_back(control_item(16'(1000), 16'(-1000), 8'd1, 32'hFFFF_FFFF));
        in_backlog.push_back(control_item(16'(1000), 16'(-1000), 8'd1, 32'hFFFF_FFFF));
        in_backlog.push_back(control_item(16'(-1000), 16'(1000), 8'd0, 32'd0));
        in_backlog.push_back(tick_item());
        in_backlog.push_back(tick_item());
        // drives one past the limit, full-scale drives, bad brake bytes
        in_backlog.push_back(control_item(16'(1001), '0, 8'd0, 32'd1));
        in_backlog.push_back(control_item('0, 16'(-1001), 8'd0, 32'd1));
        in_backlog.push_back(control_item(16'h8000, '0, 8'd0, 32'd1));
        in_backlog.push_back(control_item('0, 16'h7FFF, 8'd0, 32'd1));
        in_backlog.push_back(control_item('0, '0, 8'd2, 32'd1));
        in_backlog.push_back(control_item('0, '0, 8'hFF, 32'd1));
        // serial order: half-range ahead is stale, just under it is newer
        in_backlog.push_back(control_item('0, '0, 8'd0, 32'h8000_0000));
        in_backlog.push_back(control_item(16'd5, 16'd7, 8'd1, 32'h7FFF_FFFF));
        in_backlog.push_back(control_item('0, '0, 8'd0, 32'h7FFF_FFFE));
        in_backlog.push_back(control_item('0, '0, 8'd0, 32'h8000_0000));
        in_backlog.push_back(tick_item());
        in_backlog.push_back(frame_item(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF));
        in_backlog.push_back(frame_item(8'h00, 8'h00, '0, '0, 8'h00, '0));
        await_drain();

        // probe required, short timeout
        load_config('{8'd1, 8'd2, 8'd5, 15'd1000, 16'd20, 1'b1});
        fill_random(PHASE_ITEMS);
        await_drain();

        // top probe code, bottom control code, top length, widest limit, zero timeout
        load_config('{8'hFF, 8'h00, 8'hFF, 15'h7FFF, 16'd0, 1'b0});
        fill_random(PHASE_ITEMS);
        await_drain();

        // zero limit, longest timeout
        load_config('{8'h00, 8'hFF, 8'd5, 15'd0, 16'hFFFF, 1'b1});
        fill_random(PHASE_ITEMS);
        await_drain();

        // probe and control share one type code
        load_config('{8'h37, 8'h37, 8'd9, 15'd500, 16'd7, 1'b0});
        fill_random(PHASE_ITEMS);
        await_drain();

        // random setting
        c.probe_type_code   = 8'($urandom);
        c.control_type_code = 8'($urandom);
        c.control_length    = 8'($urandom_range(5, 255));
        c.drive_limit       = 15'($urandom_range(0, 32767));
        c.timeout_ms        = 16'($urandom_range(0, 60));
        c.require_probe     = 1'($urandom_range(0, 1));
        load_config(c);
        fill_random(PHASE_ITEMS);
        await_drain();

        // back-to-back traffic, no idling on either side
        calm = 1'b1;
        load_config('{RST_PROBE_TYPE, RST_CONTROL_TYPE, RST_CONTROL_LEN, RST_DRIVE_LIMIT,
                      16'd12, 1'b1});
        fill_random(PHASE_ITEMS);
        await_drain();
        repeat (8) @(posedge i_clk);

        $display("Summary: %0d words in, %0d results checked under %0d register settings",
                 n_in, n_out, n_settings);
        $display("Summary: %0d ok, %0d bad-frame, %0d bad-data acks, %0d ticks,",
                 n_ok, n_bad_frame, n_bad_data, n_ticks);
        $display("         %0d connected results, %0d errors", n_conn, n_errors);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
